@@ rtl/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg
// shared types and constants of the encoder settle calibrator
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int DRIVE_W    = 16;
    localparam int COUNT_W    = 5;
    localparam int BAND_W     = 31;
    localparam int SUM_W      = 37;
    localparam int REM_W      = 6;
    localparam int DIVCNT_W   = 6;
    localparam int OUT_W      = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_BAND  = 2'd2;

    localparam logic [DRIVE_W-1:0] DRIVE_RST = 16'd0;
    localparam logic [COUNT_W-1:0] COUNT_RST = 5'd8;
    localparam logic [BAND_W-1:0]  BAND_RST  = 31'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CANCEL = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_FIX    = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic check;
        logic div_step;
        logic fix;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic settled;
        logic div_done;
    } status_t;

endpackage

@@ rtl/esc_ctrl.sv @@
// ----------------------------------------------------------------------------
// esc_ctrl
// sequencer: accept, window scan, band check, divide, result hand-off
// ----------------------------------------------------------------------------
module esc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  esc_pkg::status_t st,
    output esc_pkg::cmd_t    cmd
);

    esc_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            slot_free;

    assign s_tready  = (state_reg == esc_pkg::ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            esc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = st.need_scan ? esc_pkg::ST_SCAN : esc_pkg::ST_RESULT;
                end
            end
            esc_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (st.scan_done) begin
                    state_next = esc_pkg::ST_CHECK;
                end
            end
            esc_pkg::ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = st.settled ? esc_pkg::ST_DIV : esc_pkg::ST_RESULT;
            end
            esc_pkg::ST_DIV: begin
                if (st.div_done) begin
                    state_next = esc_pkg::ST_FIX;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            esc_pkg::ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = esc_pkg::ST_RESULT;
            end
            esc_pkg::ST_RESULT: begin
                if (slot_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = esc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = esc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= esc_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

@@ rtl/esc_datapath.sv @@
// ----------------------------------------------------------------------------
// esc_datapath
// config registers, sample ring memory, min/max/sum walk, serial divider
// ----------------------------------------------------------------------------
module esc_datapath #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [esc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_op,
    input  logic [esc_pkg::SAMPLE_W-1:0]      s_sample,
    input  esc_pkg::cmd_t                     cmd,
    output esc_pkg::status_t                  st,
    output logic [esc_pkg::OUT_W-1:0]         m_payload
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
    localparam logic [esc_pkg::COUNT_W-1:0] DEPTH_CAP =
        (WINDOW_DEPTH > 31) ? 5'd31 : 5'(WINDOW_DEPTH);
    localparam logic [esc_pkg::DIVCNT_W-1:0] DIV_STEPS = 6'(esc_pkg::SUM_W);

    // configuration
    logic [esc_pkg::DRIVE_W-1:0] drive_value_reg;
    logic [esc_pkg::COUNT_W-1:0] window_count_reg;
    logic [esc_pkg::BAND_W-1:0]  settle_band_reg;

    // window memory
    logic [esc_pkg::SAMPLE_W-1:0] win_mem [WINDOW_DEPTH];
    logic [esc_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]                wp_reg;
    logic [AW-1:0]                rp_reg;

    // control state
    logic [esc_pkg::COUNT_W-1:0]  fill_reg;
    logic                         done_reg;
    logic [esc_pkg::SAMPLE_W-1:0] loc_reg;
    logic                         active_reg;
    logic                         fin_reg;
    logic [esc_pkg::COUNT_W-1:0]  issue_cnt_reg;
    logic [esc_pkg::COUNT_W-1:0]  acc_cnt_reg;
    logic                         rd_vld_reg;
    logic [esc_pkg::DIVCNT_W-1:0] div_cnt_reg;

    // working registers
    logic [esc_pkg::COUNT_W-1:0]     cnt_reg;
    logic signed [esc_pkg::SAMPLE_W-1:0] lo_reg;
    logic signed [esc_pkg::SAMPLE_W-1:0] hi_reg;
    logic signed [esc_pkg::SUM_W-1:0]    sum_reg;
    logic [esc_pkg::SUM_W-1:0]       mag_reg;
    logic [esc_pkg::REM_W-1:0]       rem_reg;
    logic                            neg_reg;
    logic [esc_pkg::OUT_W-1:0]       out_reg;

    logic [esc_pkg::COUNT_W-1:0]     eff_cnt;
    logic [esc_pkg::COUNT_W:0]       fill_inc;
    logic [esc_pkg::COUNT_W-1:0]     fill_new;
    logic                            push;
    logic                            issue;
    logic signed [esc_pkg::SAMPLE_W-1:0] rd_s;
    logic signed [esc_pkg::SAMPLE_W:0]   spread;
    logic [esc_pkg::REM_W-1:0]       den;
    logic [esc_pkg::REM_W:0]         rem_sh;
    logic                            q_bit;
    logic [esc_pkg::SAMPLE_W-1:0]    quot;
    logic [esc_pkg::DRIVE_W-1:0]     drive_out;

    always_comb begin
        eff_cnt = (window_count_reg == '0) ? 5'd1 : window_count_reg;
        if (eff_cnt > DEPTH_CAP) begin
            eff_cnt = DEPTH_CAP;
        end
    end

    assign fill_inc = {1'b0, fill_reg} + 6'd1;
    assign fill_new = (fill_inc > {1'b0, eff_cnt}) ? eff_cnt : fill_inc[esc_pkg::COUNT_W-1:0];
    assign push     = cmd.accept && !done_reg && (s_op == esc_pkg::OP_SAMPLE);
    assign issue    = cmd.scan && (issue_cnt_reg != cnt_reg);
    assign rd_s     = $signed(rd_data_reg);
    assign spread   = $signed({hi_reg[esc_pkg::SAMPLE_W-1], hi_reg})
                    - $signed({lo_reg[esc_pkg::SAMPLE_W-1], lo_reg});
    assign den      = {cnt_reg, 1'b0};
    assign rem_sh   = {rem_reg, mag_reg[esc_pkg::SUM_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, den});
    assign quot     = mag_reg[esc_pkg::SAMPLE_W-1:0];
    assign drive_out = active_reg ? drive_value_reg : '0;

    assign st.need_scan = !done_reg && (s_op == esc_pkg::OP_SAMPLE) && (fill_new == eff_cnt);
    assign st.scan_done = (acc_cnt_reg == cnt_reg);
    assign st.settled   = (spread < $signed({2'b00, settle_band_reg}));
    assign st.div_done  = (div_cnt_reg == '0);

    assign m_payload = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_value_reg  <= esc_pkg::DRIVE_RST;
            window_count_reg <= esc_pkg::COUNT_RST;
            settle_band_reg  <= esc_pkg::BAND_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                esc_pkg::CFG_DRIVE_VALUE:  drive_value_reg  <= cfg_data[esc_pkg::DRIVE_W-1:0];
                esc_pkg::CFG_WINDOW_COUNT: window_count_reg <= cfg_data[esc_pkg::COUNT_W-1:0];
                esc_pkg::CFG_SETTLE_BAND:  settle_band_reg  <= cfg_data[esc_pkg::BAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            win_mem[wp_reg] <= s_sample;
        end
        if (issue) begin
            rd_data_reg <= win_mem[rp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
            loc_reg       <= '0;
            active_reg    <= 1'b0;
            fin_reg       <= 1'b0;
            issue_cnt_reg <= '0;
            acc_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            if (cmd.accept) begin
                active_reg    <= push;
                fin_reg       <= 1'b0;
                issue_cnt_reg <= '0;
                acc_cnt_reg   <= '0;
                rd_vld_reg    <= 1'b0;
                if (!done_reg && (s_op == esc_pkg::OP_CANCEL)) begin
                    done_reg <= 1'b1;
                end
            end
            if (push) begin
                wp_reg   <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                fill_reg <= fill_new;
            end
            if (cmd.scan) begin
                rd_vld_reg <= issue;
                if (issue) begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    acc_cnt_reg <= acc_cnt_reg + 1'b1;
                end
            end
            if (cmd.check) begin
                div_cnt_reg <= DIV_STEPS;
            end
            if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            if (cmd.fix) begin
                loc_reg  <= neg_reg ? (~quot + 1'b1) : quot;
                done_reg <= 1'b1;
                fin_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cnt_reg <= eff_cnt;
            rp_reg  <= wp_reg;
        end
        if (issue) begin
            rp_reg <= (rp_reg == '0) ? LAST_ADDR : rp_reg - 1'b1;
        end
        if (cmd.scan && rd_vld_reg) begin
            if (acc_cnt_reg == '0) begin
                lo_reg  <= rd_s;
                hi_reg  <= rd_s;
                sum_reg <= {{(esc_pkg::SUM_W-esc_pkg::SAMPLE_W){rd_s[esc_pkg::SAMPLE_W-1]}}, rd_s};
            end else begin
                if (rd_s < lo_reg) begin
                    lo_reg <= rd_s;
                end
                if (rd_s > hi_reg) begin
                    hi_reg <= rd_s;
                end
                sum_reg <= sum_reg
                         + {{(esc_pkg::SUM_W-esc_pkg::SAMPLE_W){rd_s[esc_pkg::SAMPLE_W-1]}}, rd_s};
            end
        end
        // magnitude of 2*sum+1; for negative sums it is {~sum, 1}
        if (cmd.check) begin
            neg_reg <= sum_reg[esc_pkg::SUM_W-1];
            mag_reg <= {(sum_reg[esc_pkg::SUM_W-1] ? ~sum_reg[esc_pkg::SUM_W-2:0]
                                                   : sum_reg[esc_pkg::SUM_W-2:0]), 1'b1};
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            mag_reg <= {mag_reg[esc_pkg::SUM_W-2:0], q_bit};
            rem_reg <= q_bit ? 6'(rem_sh - {1'b0, den}) : rem_sh[esc_pkg::REM_W-1:0];
        end
        if (cmd.load_out) begin
            out_reg <= {5'b00000, loc_reg, fin_reg, done_reg, drive_out, active_reg};
        end
    end

endmodule

@@ rtl/encoder_settle_calibrator_core.sv @@
// ----------------------------------------------------------------------------
// encoder_settle_calibrator_core
// watches encoder samples while driving a motor and latches the settled spot
// ----------------------------------------------------------------------------
// s_ channel: one beat per step, s_tuser = op (0 sample, 1 cancel),
// s_tdata = encoder sample in ticks. cfg_ channel writes drive_value (0),
// window_count (1) and settle_band (2); cfg_ready is always high.
// m_ channel: exactly one result beat for each accepted input beat.
// Items are worked one at a time. A beat that leaves the window short of full,
// a cancel, or any beat after done skips the window scan and goes straight
// to the result hand-off.
// A sample that fills the window walks the ring memory one entry per cycle
// through its single registered read port, and when the band test passes a
// 37-step restoring divider follows before the result is loaded.
// The result sits in an output register; the next beat is accepted while it
// waits, but that item's result is held back until m_tready takes the first.
// Reset (aresetn low, synchronous) restores the register defaults, empties
// the window and clears done and location. Window contents need no clearing.
// ----------------------------------------------------------------------------
module encoder_settle_calibrator_core #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // encoder_sample[31:0]
    input  logic                           s_tuser,   // op[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // drive_active[0], drive_command[16:1], done_res[17], finished_now[18],
    // location[50:19], zero[55:51]
    output logic [esc_pkg::OUT_W-1:0]      m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_data
);

    esc_pkg::cmd_t    cmd;
    esc_pkg::status_t st;

    assign cfg_ready = 1'b1;

    esc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    esc_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_op      (s_tuser),
        .s_sample  (s_tdata),
        .cmd       (cmd),
        .st        (st),
        .m_payload (m_tdata)
    );

endmodule

@@ rtl/esc_checker.sv @@
// ----------------------------------------------------------------------------
// esc_checker
// port-level checks of the calibrator result stream
// ----------------------------------------------------------------------------
module esc_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [esc_pkg::OUT_W-1:0] m_tdata
);

    // stalled result beat stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // idle drive means a zero command
    a_idle_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[16:1] == 16'd0))
        else $error("drive command nonzero while inactive");

    // settling step is a driven step that reports done
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> m_tdata[17] && m_tdata[0])
        else $error("finished without done or drive");

    // drive together with done only on the settling step
    a_drive_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] && m_tdata[17] |-> m_tdata[18])
        else $error("driving after calibration done");

endmodule

bind encoder_settle_calibrator_core esc_checker u_esc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/tb_encoder_settle_calibrator_core.sv @@
// ----------------------------------------------------------------------------
// tb_encoder_settle_calibrator_core
// self-checking bench for the encoder settle calibrator core
// ----------------------------------------------------------------------------
// A predictor in the bench tracks the sample window, the fill level, the done
// flag and the latched location, and queues the expected result for every
// accepted beat. Directed beats cover the reset defaults, extreme samples and
// the odd window counts. Random phases then rewrite all registers and stream
// samples whose windows often sit exactly on the band edge but never settle.
// The run ends with either a settle on the band edge or a cancel, followed by
// beats sent while done. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_encoder_settle_calibrator_core;

    localparam int     WIN_DEPTH   = 16;
    localparam int     STALL_LIMIT = 2000;
    localparam int     PHASES      = 7;
    localparam int     PHASE_BEATS = 85;
    localparam longint SMIN        = -(longint'(1) <<< 31);
    localparam longint SMAX        = (longint'(1) <<< 31) - 1;

    typedef struct packed {
        logic [4:0]         spare;
        logic signed [31:0] location;
        logic               finished_now;
        logic               done;
        logic signed [15:0] command;
        logic               active;
    } calib_result_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [31:0]                    s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [esc_pkg::OUT_W-1:0]      m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [esc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    logic [esc_pkg::DRIVE_W-1:0] drive_reg = esc_pkg::DRIVE_RST;
    logic [esc_pkg::COUNT_W-1:0] count_reg = esc_pkg::COUNT_RST;
    logic [esc_pkg::BAND_W-1:0]  band_reg  = esc_pkg::BAND_RST;
    logic signed [31:0]          window [WIN_DEPTH];
    int                          fill         = 0;
    bit                          cal_done     = 1'b0;
    logic signed [31:0]          cal_location = '0;

    calib_result_t pending_results [$];
    int            mismatch_count = 0;
    int            idle_cycles    = 0;
    int            stall_left     = 0;
    bit            calm           = 1'b0;

    encoder_settle_calibrator_core #(
        .WINDOW_DEPTH (WIN_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int win_len();
        int n;
        n = count_reg;
        if (n == 0) n = 1;
        if (n > WIN_DEPTH) n = WIN_DEPTH;
        return n;
    endfunction

    function automatic calib_result_t calibrate_step(logic op, logic [31:0] sample);
        calib_result_t r;
        int            n;
        int            i;
        longint        lo;
        longint        hi;
        longint        total;
        r = '0;
        if (!cal_done) begin
            if (op == esc_pkg::OP_CANCEL) begin
                cal_done = 1'b1;
            end else begin
                n = win_len();
                r.active  = 1'b1;
                r.command = drive_reg;
                for (i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
                window[0] = sample;
                fill = (fill + 1 > n) ? n : fill + 1;
                if (fill == n) begin
                    lo    = window[0];
                    hi    = window[0];
                    total = 0;
                    for (i = 0; i < n; i++) begin
                        if (window[i] < lo) lo = window[i];
                        if (window[i] > hi) hi = window[i];
                        total += window[i];
                    end
                    if (hi - lo < longint'(band_reg)) begin
                        cal_location   = 32'((2 * total + 1) / (2 * longint'(n)));
                        cal_done       = 1'b1;
                        r.finished_now = 1'b1;
                    end
                end
            end
        end
        r.done     = cal_done;
        r.location = cal_location;
        return r;
    endfunction

    // moves a sample away from the others when it would settle the window
    function automatic longint keep_unsettled(longint s);
        int     n;
        int     i;
        longint lo;
        longint hi;
        n = win_len();
        if (cal_done || band_reg == 0 || n < 2 || fill + 1 < n) return s;
        lo = window[0];
        hi = window[0];
        for (i = 1; i < n - 1; i++) begin
            if (window[i] < lo) lo = window[i];
            if (window[i] > hi) hi = window[i];
        end
        if ((s > hi ? s : hi) - (s < lo ? s : lo) >= longint'(band_reg)) return s;
        if (hi - longint'(band_reg) >= SMIN) return hi - longint'(band_reg);
        return lo + longint'(band_reg);
    endfunction

    function automatic longint rand_between(longint lo, longint hi);
        longint unsigned span;
        span = longint'(hi - lo + 1);
        return lo + longint'({$urandom, $urandom} % span);
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void note_mismatch(string what, longint want, longint got);
        if (mismatch_count < 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
        mismatch_count++;
    endfunction

    always @(posedge aclk) begin : check_results
        calib_result_t got;
        calib_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = calib_result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result beat, location", 0, got.location);
            end else begin
                want = pending_results.pop_front();
                if (got.active !== want.active)
                    note_mismatch("drive_active", want.active, got.active);
                if (got.command !== want.command)
                    note_mismatch("drive_command", want.command, got.command);
                if (got.done !== want.done)
                    note_mismatch("done_res", want.done, got.done);
                if (got.finished_now !== want.finished_now)
                    note_mismatch("finished_now", want.finished_now, got.finished_now);
                if (got.location !== want.location)
                    note_mismatch("location", want.location, got.location);
                if (got.spare !== 5'd0)
                    note_mismatch("padding", 0, got.spare);
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pause_len();
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic send_item(logic op, logic [31:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(calibrate_step(op, data));
        gap = pause_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_sample(longint s);
        send_item(esc_pkg::OP_SAMPLE, 32'(keep_unsettled(s)));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_regs(logic [15:0] drive, logic [4:0] count, logic [30:0] band);
        logic [esc_pkg::CFG_IDX_W-1:0]  idxs [3];
        logic [esc_pkg::CFG_DATA_W-1:0] vals [3];
        int                             i;
        drain_results();
        idxs = '{esc_pkg::CFG_DRIVE_VALUE, esc_pkg::CFG_WINDOW_COUNT,
                 esc_pkg::CFG_SETTLE_BAND};
        vals = '{esc_pkg::CFG_DATA_W'(drive), esc_pkg::CFG_DATA_W'(count), band};
        for (i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        drive_reg = drive;
        count_reg = count;
        band_reg  = band;
    endtask

    task automatic send_after_done();
        send_item(esc_pkg::OP_SAMPLE, $urandom);
        send_item(esc_pkg::OP_CANCEL, $urandom);
        send_item(esc_pkg::OP_SAMPLE, 32'h8000_0000);
        send_item(esc_pkg::OP_SAMPLE, 32'h7FFF_FFFF);
    endtask

    // defaults: count 8, band 2, drive 0; full-scale spread in the band test
    task automatic test_reset_defaults();
        send_sample(SMIN);
        send_sample(SMAX);
        send_sample(0);
        send_sample(-1);
        send_sample(32'h5555_5555);
        send_sample(int'(32'hAAAA_AAAA));
        send_sample(1);
        send_sample(SMIN);
        send_sample(SMAX);
    endtask

    task automatic test_window_edges();
        // count of zero acts as one, window trimmed from full
        write_regs(16'h7FFF, 5'd0, 31'd0);
        send_sample(SMAX);
        send_sample(SMIN);
        // count above depth saturates, widest band
        write_regs(16'h8000, 5'd31, 31'h7FFF_FFFF);
        repeat (3) begin
            send_sample(SMIN);
            send_sample(SMAX);
        end
        write_regs(16'h0001, 5'd17, 31'd0);
        repeat (3) send_sample(int'($urandom));
        // count lowered below the fill level
        write_regs(16'hFFFF, 5'd3, 31'h7FFF_FFFF);
        send_sample(SMIN);
        send_sample(SMAX);
        send_sample(SMIN);
    endtask

    task automatic test_random_windows();
        int          phase;
        int          k;
        int          r;
        logic [4:0]  count;
        logic [30:0] band;
        logic [15:0] drive;
        longint      base;
        longint      s;
        for (phase = 0; phase < PHASES; phase++) begin
            r = $urandom_range(0, 9);
            if (r == 0) count = 5'd0;
            else if (r == 1) count = 5'd1;
            else if (r == 2) count = 5'd16;
            else if (r == 3) count = 5'($urandom_range(17, 31));
            else count = 5'($urandom_range(2, 15));
            r = $urandom_range(0, 9);
            if (r == 0) band = 31'd0;
            else if (r == 1) band = 31'd1;
            else if (r == 2) band = 31'h7FFF_FFFF;
            else if (r == 3) band = 31'($urandom_range(2, 100));
            else if (r < 6) band = 31'($urandom_range(0, 32'h7FFF_FFFF));
            else band = 31'($urandom_range(1, 65535));
            if (count < 5'd2) band = 31'd0;
            r = $urandom_range(0, 5);
            if (r == 0) drive = 16'h8000;
            else if (r == 1) drive = 16'h7FFF;
            else if (r == 2) drive = 16'h0000;
            else drive = 16'($urandom);
            calm = ($urandom_range(0, 3) == 0);
            write_regs(drive, count, band);
            base = rand_between(SMIN, SMAX - longint'(band));
            for (k = 0; k < PHASE_BEATS; k++) begin
                if ($urandom_range(0, 19) == 0)
                    base = rand_between(SMIN, SMAX - longint'(band));
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    case ($urandom_range(0, 2))
                        0: s = base;
                        1: s = base + longint'(band);
                        default: s = base + rand_between(0, longint'(band));
                    endcase
                end else if (r < 85) begin
                    s = int'($urandom);
                end else begin
                    case ($urandom_range(0, 3))
                        0: s = SMIN;
                        1: s = SMAX;
                        2: s = 0;
                        default: s = -1;
                    endcase
                end
                send_sample(s);
            end
        end
        calm = 1'b0;
    endtask

    // window spread one below the band: settles, then everything is ignored
    task automatic test_settle_and_hold();
        int          r;
        int          i;
        logic [4:0]  count;
        logic [30:0] band;
        longint      band_l;
        longint      base;
        longint      off;
        count = ($urandom_range(0, 2) == 0) ? 5'd16 : 5'($urandom_range(0, 31));
        r = $urandom_range(0, 4);
        if (r == 0) band = 31'd1;
        else if (r == 1) band = 31'h7FFF_FFFF;
        else if (r == 2) band = 31'($urandom_range(2, 64));
        else band = 31'($urandom_range(1, 32'h0010_0000));
        write_regs(16'($urandom), count, band);
        band_l = band;
        r = $urandom_range(0, 3);
        if (r == 0) base = SMIN;
        else if (r == 1) base = SMAX - (band_l - 1);
        else base = rand_between(SMIN, SMAX - (band_l - 1));
        i = 0;
        while (!cal_done) begin
            if (i == 0) off = 0;
            else if (i == 1) off = band_l - 1;
            else off = rand_between(0, band_l - 1);
            send_item(esc_pkg::OP_SAMPLE, 32'(base + off));
            i++;
        end
        send_after_done();
    endtask

    task automatic test_cancel_and_hold();
        repeat (3) send_sample(int'($urandom));
        send_item(esc_pkg::OP_CANCEL, $urandom);
        send_after_done();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_window_edges();
        test_random_windows();
        if ($urandom_range(0, 1) == 0)
            test_settle_and_hold();
        else
            test_cancel_and_hold();
        drain_results();
        repeat (80) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
